@@ hdl/fltd_pkg.sv @@
// ----------------------------------------------------------------------------
// fltd_pkg
// Shared types and constants of the FLV tag deframer: descriptor layout,
// event and tag kind codes, stream signature and header lengths.
// ----------------------------------------------------------------------------
`default_nettype none

package fltd_pkg;

    // Event codes carried in event_res
    localparam logic [1:0] EV_TAG_DONE   = 2'd0;
    localparam logic [1:0] EV_BAD_SIG    = 2'd1;
    localparam logic [1:0] EV_BAD_OFFSET = 2'd2;
    localparam logic [1:0] EV_BAD_TYPE   = 2'd3;

    // Tag kind codes carried in tag_kind
    localparam logic [1:0] KIND_AUDIO  = 2'd0;
    localparam logic [1:0] KIND_VIDEO  = 2'd1;
    localparam logic [1:0] KIND_SCRIPT = 2'd2;

    // Tag type bytes as they appear in the stream
    localparam logic [7:0] TYPE_AUDIO  = 8'h08;
    localparam logic [7:0] TYPE_VIDEO  = 8'h09;
    localparam logic [7:0] TYPE_SCRIPT = 8'h12;

    // Signature "FLV"
    localparam logic [7:0] SIG_BYTE0 = 8'h46;
    localparam logic [7:0] SIG_BYTE1 = 8'h4C;
    localparam logic [7:0] SIG_BYTE2 = 8'h56;

    // Codec id that carries an AVC packet type byte
    localparam logic [3:0] CODEC_AVC = 4'd7;

    // Byte indices in the fixed sections (mostly last index, 24-bit counter) and the header offset value
    localparam logic [23:0] SIG_LAST      = 24'd2;
    localparam logic [23:0] HDR_OFS_FIRST = 24'd2;
    localparam logic [23:0] HDR_LAST      = 24'd5;
    localparam logic [23:0] PTS_LAST      = 24'd3;
    localparam logic [23:0] TAG_SIZE_LAST = 24'd3;
    localparam logic [23:0] TAG_TIME_LAST = 24'd6;
    localparam logic [23:0] TAG_TEXT_IDX  = 24'd7;
    localparam logic [23:0] TAG_LAST      = 24'd10;
    localparam logic [31:0] HDR_OFFSET    = 32'd9;

    // One input byte request between the input stage and the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_req_t;

    // One result descriptor
    typedef struct packed {
        logic [1:0]  event_res;
        logic [1:0]  tag_kind;
        logic [23:0] data_size;
        logic [31:0] timestamp;
        logic [23:0] stream_id;
        logic [3:0]  video_frame_type;
        logic [3:0]  video_codec;
        logic [7:0]  avc_packet_type;
        logic [3:0]  audio_format;
        logic [1:0]  audio_rate;
        logic        audio_bits;
        logic        audio_stereo;
    } desc_t;

    // Expected signature byte at a given position
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] val;
        unique case (idx)
            2'd0:    val = SIG_BYTE0;
            2'd1:    val = SIG_BYTE1;
            2'd2:    val = SIG_BYTE2;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

@@ hdl/fltd_if.sv @@
// ----------------------------------------------------------------------------
// fltd_if
// Valid/ready channel interfaces: the byte stream in and the descriptor out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fltd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface fltd_desc_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [1:0]  tag_kind;
    logic [23:0] data_size;
    logic [31:0] timestamp;
    logic [23:0] stream_id;
    logic [3:0]  video_frame_type;
    logic [3:0]  video_codec;
    logic [7:0]  avc_packet_type;
    logic [3:0]  audio_format;
    logic [1:0]  audio_rate;
    logic        audio_bits;
    logic        audio_stereo;

    modport source (
        output valid, output event_res, output tag_kind, output data_size,
        output timestamp, output stream_id, output video_frame_type,
        output video_codec, output avc_packet_type, output audio_format,
        output audio_rate, output audio_bits, output audio_stereo,
        input ready
    );
    modport sink (
        input valid, input event_res, input tag_kind, input data_size,
        input timestamp, input stream_id, input video_frame_type,
        input video_codec, input avc_packet_type, input audio_format,
        input audio_rate, input audio_bits, input audio_stereo,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/fltd_in_stage.sv @@
// ----------------------------------------------------------------------------
// fltd_in_stage
// Input register: holds one stream byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fltd_in_stage
    import fltd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    output logic            in_ready,
    input  wire logic       take,
    output byte_req_t       req
);

    logic       valid_reg;
    logic [7:0] data_reg;

    // Accept when empty or when the held byte leaves this cycle
    assign in_ready = !valid_reg || take;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load the byte
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_byte;
        end
    end

    assign req.valid = valid_reg;
    assign req.data  = data_reg;

endmodule

`default_nettype wire

@@ hdl/fltd_parser.sv @@
// ----------------------------------------------------------------------------
// fltd_parser
// Per-byte FLV parse state machine with the registered descriptor output.
// ----------------------------------------------------------------------------
`default_nettype none

module fltd_parser
    import fltd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  byte_req_t      req,
    output logic           take,
    output logic           res_valid,
    input  wire logic      res_ready,
    output desc_t          res
);

    typedef enum logic [2:0] {
        PH_SIG,
        PH_HDR,
        PH_PTS,
        PH_TAG,
        PH_DATA
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [23:0] count_reg,  count_next;
    logic [1:0]  kind_reg,   kind_next;
    logic [23:0] size_reg,   size_next;
    logic [31:0] time_reg,   time_next;
    logic [23:0] stream_reg, stream_next;
    logic [7:0]  first_reg,  first_next;
    logic [7:0]  second_reg, second_next;
    logic        halted_reg, halted_next;
    logic        valid_reg,  valid_next;
    desc_t       desc_reg,   desc_next;
    logic        emit;
    logic [7:0]  b;

    // Build a tag descriptor from the captured header and payload bytes
    function automatic desc_t build_tag(
        input logic [1:0]  kind,
        input logic [23:0] size,
        input logic [31:0] stamp,
        input logic [23:0] sid,
        input logic [7:0]  first,
        input logic [7:0]  second
    );
        desc_t d;
        d           = '0;
        d.event_res = EV_TAG_DONE;
        d.tag_kind  = kind;
        d.data_size = size;
        d.timestamp = stamp;
        d.stream_id = sid;
        if (kind == KIND_VIDEO)
        begin
            d.video_frame_type = first[7:4];
            d.video_codec      = first[3:0];
            if (first[3:0] == CODEC_AVC)
            begin
                d.avc_packet_type = second;
            end
        end
        else if (kind == KIND_AUDIO)
        begin
            d.audio_format = first[7:4];
            d.audio_rate   = first[3:2];
            d.audio_bits   = first[1];
            d.audio_stereo = first[0];
        end
        return d;
    endfunction

    // Error descriptor: event code only
    function automatic desc_t build_err(input logic [1:0] code);
        desc_t d;
        d           = '0;
        d.event_res = code;
        return d;
    endfunction

    // Take the held byte when the result register is free or drains now
    assign take = req.valid && (!valid_reg || res_ready);
    assign b    = req.data;

    // Next state and descriptor for one byte
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        size_next   = size_reg;
        time_next   = time_reg;
        stream_next = stream_reg;
        first_next  = first_reg;
        second_next = second_reg;
        halted_next = halted_reg;
        emit        = 1'b0;
        desc_next   = desc_reg;

        if (take && !halted_reg)
        begin
            unique case (phase_reg)
                PH_SIG:
                begin
                    if (count_reg > SIG_LAST || b != sig_byte(count_reg[1:0]))
                    begin
                        halted_next = 1'b1;
                        emit        = 1'b1;
                        desc_next   = build_err(EV_BAD_SIG);
                    end
                    else if (count_reg == SIG_LAST)
                    begin
                        phase_next = PH_HDR;
                        count_next = '0;
                        time_next  = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 24'd1;
                    end
                end
                PH_HDR:
                begin
                    if (count_reg >= HDR_OFS_FIRST)
                    begin
                        time_next = {time_reg[23:0], b};
                    end
                    count_next = count_reg + 24'd1;
                    if (count_reg == HDR_LAST)
                    begin
                        if (time_next != HDR_OFFSET)
                        begin
                            halted_next = 1'b1;
                            emit        = 1'b1;
                            desc_next   = build_err(EV_BAD_OFFSET);
                        end
                        else
                        begin
                            time_next  = '0;
                            phase_next = PH_PTS;
                            count_next = '0;
                        end
                    end
                end
                PH_PTS:
                begin
                    // Skip the previous-tag-size field
                    if (count_reg >= PTS_LAST)
                    begin
                        phase_next = PH_TAG;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 24'd1;
                    end
                end
                PH_TAG:
                begin
                    if (count_reg == '0)
                    begin
                        size_next   = '0;
                        time_next   = '0;
                        stream_next = '0;
                        first_next  = '0;
                        second_next = '0;
                        priority if (b == TYPE_AUDIO)
                        begin
                            kind_next = KIND_AUDIO;
                        end
                        else if (b == TYPE_VIDEO)
                        begin
                            kind_next = KIND_VIDEO;
                        end
                        else if (b == TYPE_SCRIPT)
                        begin
                            kind_next = KIND_SCRIPT;
                        end
                        else
                        begin
                            halted_next = 1'b1;
                            emit        = 1'b1;
                            desc_next   = build_err(EV_BAD_TYPE);
                        end
                    end
                    else if (count_reg <= TAG_SIZE_LAST)
                    begin
                        size_next = {size_reg[15:0], b};
                    end
                    else if (count_reg <= TAG_TIME_LAST)
                    begin
                        time_next = {8'h00, time_reg[15:0], b};
                    end
                    else if (count_reg == TAG_TEXT_IDX)
                    begin
                        time_next = {b, time_reg[23:0]};
                    end
                    else
                    begin
                        stream_next = {stream_reg[15:0], b};
                    end

                    count_next = count_reg + 24'd1;
                    if (!halted_next && count_reg >= TAG_LAST)
                    begin
                        count_next = '0;
                        if (size_next == '0)
                        begin
                            emit       = 1'b1;
                            phase_next = PH_PTS;
                            desc_next  = build_tag(kind_next, size_next, time_next,
                                                   stream_next, first_next,
                                                   second_next);
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (count_reg == 24'd0)
                    begin
                        first_next = b;
                    end
                    else if (count_reg == 24'd1)
                    begin
                        second_next = b;
                    end
                    count_next = count_reg + 24'd1;
                    if (count_next >= size_reg)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_PTS;
                        count_next = '0;
                        desc_next  = build_tag(kind_next, size_next, time_next,
                                               stream_next, first_next,
                                               second_next);
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        // Result register: load on a new result, drop when taken
        if (take)
        begin
            valid_next = emit;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Hold state and the registered descriptor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG;
            count_reg  <= '0;
            kind_reg   <= '0;
            size_reg   <= '0;
            time_reg   <= '0;
            stream_reg <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            halted_reg <= 1'b0;
            valid_reg  <= 1'b0;
            desc_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            kind_reg   <= kind_next;
            size_reg   <= size_next;
            time_reg   <= time_next;
            stream_reg <= stream_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            halted_reg <= halted_next;
            valid_reg  <= valid_next;
            desc_reg   <= desc_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = desc_reg;

    // Halt persists until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt cleared without reset");

    // No new descriptor once halted
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg && !valid_reg |=> !valid_reg)
        else $error("descriptor produced while halted");

    // A stalled descriptor is neither lost nor altered
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !res_ready |=> valid_reg && $stable(desc_reg))
        else $error("stalled descriptor changed");

    // Error descriptors carry the event code only
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && desc_reg.event_res != EV_TAG_DONE |->
            desc_reg.tag_kind == '0 && desc_reg.data_size == '0 &&
            desc_reg.timestamp == '0 && halted_reg)
        else $error("error descriptor carries tag fields");

    // Tag kind code is never the unused value
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> desc_reg.tag_kind != 2'd3)
        else $error("bad tag kind code");

endmodule

`default_nettype wire

@@ hdl/flv_tag_deframer_core.sv @@
// ----------------------------------------------------------------------------
// flv_tag_deframer_core
// FLV stream deframer: validates the file header and emits one descriptor
// per tag, or one error descriptor after which it halts.
// ----------------------------------------------------------------------------
// Usage:
//   stream : byte request channel, one FLV file byte per request.
//   descr  : descriptor channel, at most one descriptor per byte; most
//            bytes produce none.
//   Path: a byte accepted into the input register is parsed by the
//   parse logic into the result register, where its descriptor, if any,
//   is then valid.
//   Throughput: one byte per cycle while descriptors are taken; the per-byte
//   state machine handles each byte and the result register drains while
//   the next byte is parsed.
//   Receiver stall: a held descriptor blocks the parser, the input
//   register then fills and stream.ready drops; nothing is lost.
//   After a bad signature, header offset or tag type the block reports
//   the error once and then keeps accepting and discarding bytes.
//   Reset: rst_n clears the parser to expect the signature and empties
//   both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module flv_tag_deframer_core
    import fltd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    fltd_byte_if.sink    stream,
    fltd_desc_if.source  descr
);

    byte_req_t req;
    logic      take;
    desc_t     res;

    fltd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .in_byte  (stream.stream_byte),
        .in_ready (stream.ready),
        .take     (take),
        .req      (req)
    );

    fltd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .take      (take),
        .res_valid (descr.valid),
        .res_ready (descr.ready),
        .res       (res)
    );

    // Spread the descriptor over the channel fields
    assign descr.event_res        = res.event_res;
    assign descr.tag_kind         = res.tag_kind;
    assign descr.data_size        = res.data_size;
    assign descr.timestamp        = res.timestamp;
    assign descr.stream_id        = res.stream_id;
    assign descr.video_frame_type = res.video_frame_type;
    assign descr.video_codec      = res.video_codec;
    assign descr.avc_packet_type  = res.avc_packet_type;
    assign descr.audio_format     = res.audio_format;
    assign descr.audio_rate       = res.audio_rate;
    assign descr.audio_bits       = res.audio_bits;
    assign descr.audio_stereo     = res.audio_stereo;

endmodule

`default_nettype wire
